### hw/rtl/idiv_pkg.sv
// Shared types and constants for the 64-bit restoring divider.
// Depends on nothing; all other files of the block but idiv_fifo refer to it by scoped names.
package idiv_pkg;

  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // Classification of one division, carried alongside the operands.
  typedef struct packed {
    err_t err;
    logic neg_q;
    logic neg_r;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

### hw/rtl/int64_restoring_divider.sv
// Integer divider, unsigned or signed, by pipelined restoring division.
// Depends on idiv_pkg, idiv_front, idiv_fifo and idiv_back.
//
// One division enters per clock cycle and one result leaves per cycle while
// nothing stalls. A transaction passes the front register, the four-entry
// queue, WIDTH divider stages (one quotient bit each) and the output register.
// A stall on the output freezes the divider stages; the queue and the front
// register keep taking input until the queue is full. Signed mode truncates
// toward zero and gives the remainder the sign of the dividend. A zero divisor
// reports error 1, the most negative value divided by minus one in signed mode
// reports error 2, and both return zero quotient and remainder. Only the low
// WIDTH bits of the operands are used and the result bits above WIDTH are zero.
module int64_restoring_divider #(
  parameter int WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [idiv_pkg::DATA_W-1:0] in_dividend,
  input  logic [idiv_pkg::DATA_W-1:0] in_divisor,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [idiv_pkg::DATA_W-1:0] out_quotient,
  output logic [idiv_pkg::DATA_W-1:0] out_remainder,
  output logic [1:0]                  out_error
);

  localparam int QW = idiv_pkg::CTL_W + 2 * WIDTH;

  logic             push_valid, push_full;
  idiv_pkg::ctl_t   push_ctl;
  logic [WIDTH-1:0] push_num, push_den;
  logic             pop_valid, pop_stall;
  logic [QW-1:0]    pop_data;
  idiv_pkg::ctl_t   pop_ctl;
  logic [WIDTH-1:0] pop_num, pop_den;

  idiv_front #(.WIDTH(WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .push_valid  (push_valid),
    .push_full   (push_full),
    .push_ctl    (push_ctl),
    .push_num    (push_num),
    .push_den    (push_den)
  );

  idiv_fifo #(.DW(QW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  ({push_ctl, push_num, push_den}),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  assign pop_ctl = idiv_pkg::ctl_t'(pop_data[QW-1 -: idiv_pkg::CTL_W]);
  assign pop_num = pop_data[2*WIDTH-1 -: WIDTH];
  assign pop_den = pop_data[WIDTH-1:0];

  idiv_back #(.WIDTH(WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_stall     (pop_stall),
    .pop_ctl       (pop_ctl),
    .pop_num       (pop_num),
    .pop_den       (pop_den),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder),
    .out_error     (out_error)
  );

endmodule

### hw/rtl/idiv_front.sv
// Front end: accepts input transactions, detects the error cases and takes
// operand magnitudes. Depends on idiv_pkg.
module idiv_front #(
  parameter int WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [idiv_pkg::DATA_W-1:0] in_dividend,
  input  logic [idiv_pkg::DATA_W-1:0] in_divisor,
  output logic                        push_valid,
  input  logic                        push_full,
  output idiv_pkg::ctl_t              push_ctl,
  output logic [WIDTH-1:0]            push_num,
  output logic [WIDTH-1:0]            push_den
);

  logic               vld_r, vld_nxt;
  idiv_pkg::ctl_t     ctl_r, ctl_nxt;
  logic [WIDTH-1:0]   num_r, num_nxt;
  logic [WIDTH-1:0]   den_r, den_nxt;
  logic [WIDTH-1:0]   a, b;
  logic               a_neg, b_neg;
  logic               accept, push;

  assign a        = in_dividend[WIDTH-1:0];
  assign b        = in_divisor[WIDTH-1:0];
  assign a_neg    = in_func & a[WIDTH-1];
  assign b_neg    = in_func & b[WIDTH-1];
  assign in_stall = vld_r & push_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = vld_r & ~push_full;

  always_comb begin
    ctl_nxt.neg_q = a_neg ^ b_neg;
    ctl_nxt.neg_r = a_neg;
    priority if (b == '0) begin
      ctl_nxt.err = idiv_pkg::ERR_DIV_ZERO;
    end else if (in_func && (a == {1'b1, {(WIDTH-1){1'b0}}}) && (b == '1)) begin
      ctl_nxt.err = idiv_pkg::ERR_OVERFLOW;
    end else begin
      ctl_nxt.err = idiv_pkg::ERR_NONE;
    end
    num_nxt = a_neg ? (~a + 1'b1) : a;
    den_nxt = b_neg ? (~b + 1'b1) : b;
  end

  always_comb begin
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r <= ctl_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign push_valid = vld_r;
  assign push_ctl   = ctl_r;
  assign push_num   = num_r;
  assign push_den   = den_r;

endmodule

### hw/rtl/idiv_fifo.sv
// Four-entry queue between the front end and the divider pipeline.
// Depends on nothing outside this file.
module idiv_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_full,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_stall,
  output logic [DW-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_full = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid & ~push_full;
  assign pop       = pop_valid & ~pop_stall;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

### hw/rtl/idiv_back.sv
// Back end: a WIDTH-stage restoring division pipeline, one quotient bit per
// stage, then sign correction into the output register. Depends on idiv_pkg.
module idiv_back #(
  parameter int WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_stall,
  input  idiv_pkg::ctl_t              pop_ctl,
  input  logic [WIDTH-1:0]            pop_num,
  input  logic [WIDTH-1:0]            pop_den,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [idiv_pkg::DATA_W-1:0] out_quotient,
  output logic [idiv_pkg::DATA_W-1:0] out_remainder,
  output logic [1:0]                  out_error
);

  logic [WIDTH-1:0]   rem_r [WIDTH];
  logic [WIDTH-1:0]   qn_r  [WIDTH];
  logic [WIDTH-1:0]   den_r [WIDTH];
  idiv_pkg::ctl_t     ctl_r [WIDTH];
  logic [WIDTH-1:0]   vld_r;
  logic               advance;

  logic                        out_valid_r;
  logic [idiv_pkg::DATA_W-1:0] quot_r, quot_nxt;
  logic [idiv_pkg::DATA_W-1:0] rem_out_r, rem_out_nxt;
  idiv_pkg::err_t              err_r;
  logic [WIDTH-1:0]            q_fin, r_fin;
  idiv_pkg::ctl_t              ctl_fin;

  // The whole pipeline holds while a finished result waits at the output.
  assign advance   = ~(out_valid_r & out_stall);
  assign pop_stall = ~advance;

  for (genvar s = 0; s < WIDTH; s++) begin : g_stage
    logic [WIDTH-1:0] rem_in, qn_in, den_in;
    idiv_pkg::ctl_t   ctl_in;
    logic             vld_in;
    logic [WIDTH-1:0] shifted;
    logic [WIDTH:0]   diff;
    logic             take;

    if (s == 0) begin : g_head
      assign rem_in = '0;
      assign qn_in  = pop_num;
      assign den_in = pop_den;
      assign ctl_in = pop_ctl;
      assign vld_in = pop_valid;
    end else begin : g_body
      assign rem_in = rem_r[s-1];
      assign qn_in  = qn_r[s-1];
      assign den_in = den_r[s-1];
      assign ctl_in = ctl_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    // The bit shifted out of the partial remainder takes part in the compare,
    // so divisors with the top bit set still divide correctly.
    assign shifted = {rem_in[WIDTH-2:0], qn_in[WIDTH-1]};
    assign diff    = {rem_in[WIDTH-1], shifted} - {1'b0, den_in};
    assign take    = ~diff[WIDTH];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (advance) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_r[s] <= take ? diff[WIDTH-1:0] : shifted;
        qn_r[s]  <= {qn_in[WIDTH-2:0], take};
        den_r[s] <= den_in;
        ctl_r[s] <= ctl_in;
      end
    end
  end

  assign ctl_fin = ctl_r[WIDTH-1];
  assign q_fin   = ctl_fin.neg_q ? (~qn_r[WIDTH-1] + 1'b1) : qn_r[WIDTH-1];
  assign r_fin   = ctl_fin.neg_r ? (~rem_r[WIDTH-1] + 1'b1) : rem_r[WIDTH-1];

  always_comb begin
    if (ctl_fin.err == idiv_pkg::ERR_NONE) begin
      quot_nxt    = idiv_pkg::DATA_W'(q_fin);
      rem_out_nxt = idiv_pkg::DATA_W'(r_fin);
    end else begin
      quot_nxt    = '0;
      rem_out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld_r[WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quot_r    <= quot_nxt;
      rem_out_r <= rem_out_nxt;
      err_r     <= ctl_fin.err;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_quotient  = quot_r;
  assign out_remainder = rem_out_r;
  assign out_error     = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (err_r != idiv_pkg::ERR_NONE)) |->
      ((quot_r == '0) && (rem_out_r == '0)))
    else $error("error result carries a nonzero quotient or remainder");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> pop_stall)
    else $error("queue popped while the output was stalled");

endmodule

### tb/int64_restoring_divider_checker.sv
// Result checker for int64_restoring_divider: it watches both channels, predicts each
// division and compares the returned quotient, remainder and error code field by field.
// Depends on idiv_pkg for the data width and the error codes.
module int64_restoring_divider_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_func,
  input  logic [idiv_pkg::DATA_W-1:0] in_dividend,
  input  logic [idiv_pkg::DATA_W-1:0] in_divisor,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [idiv_pkg::DATA_W-1:0] out_quotient,
  input  logic [idiv_pkg::DATA_W-1:0] out_remainder,
  input  logic [1:0]                  out_error,
  output int                          mismatches,
  output int                          outstanding,
  output int                          checked
);

  localparam int W = idiv_pkg::DATA_W;
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0]    quotient;
    logic [W-1:0]    remainder;
    idiv_pkg::err_t  err;
  } division_result_t;

  division_result_t expected_divisions[$];

  // Signed mode divides magnitudes, then fixes the signs: the quotient is negative
  // when the operand signs differ, the remainder follows the dividend.
  function automatic division_result_t divide_expected(input logic is_signed,
                                                       input logic [W-1:0] a,
                                                       input logic [W-1:0] b);
    division_result_t res;
    logic             a_neg;
    logic             b_neg;
    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    res = '0;
    res.err = idiv_pkg::ERR_NONE;
    if (b == '0) begin
      res.err = idiv_pkg::ERR_DIV_ZERO;
    end else if (!is_signed) begin
      res.quotient  = a / b;
      res.remainder = a % b;
    end else if (a == MIN_NEG && b == '1) begin
      res.err = idiv_pkg::ERR_OVERFLOW;
    end else begin
      a_neg = a[W-1];
      b_neg = b[W-1];
      mag_a = a_neg ? (~a + 1'b1) : a;
      mag_b = b_neg ? (~b + 1'b1) : b;
      res.quotient  = mag_a / mag_b;
      res.remainder = mag_a % mag_b;
      if (a_neg != b_neg) res.quotient = ~res.quotient + 1'b1;
      if (a_neg) res.remainder = ~res.remainder + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    division_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_divisions.size() == 0) begin
          mismatches++;
          $display("%0t: result with no division pending: quotient %h remainder %h error %0d",
                   $time, out_quotient, out_remainder, out_error);
        end else begin
          want = expected_divisions.pop_front();
          if (out_quotient !== want.quotient) begin
            mismatches++;
            $display("%0t: quotient mismatch: expected %h actual %h",
                     $time, want.quotient, out_quotient);
          end
          if (out_remainder !== want.remainder) begin
            mismatches++;
            $display("%0t: remainder mismatch: expected %h actual %h",
                     $time, want.remainder, out_remainder);
          end
          if (out_error !== want.err) begin
            mismatches++;
            $display("%0t: error code mismatch: expected %0d actual %0d",
                     $time, want.err, out_error);
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_divisions.push_back(divide_expected(in_func, in_dividend, in_divisor));
      end
    end
    outstanding <= expected_divisions.size();
  end

endmodule

### tb/int64_restoring_divider_test.sv
// Top of the int64_restoring_divider testbench: clock, reset, division stimulus with
// random gaps and output stalls, and the verdict. Depends on idiv_pkg, the divider
// and int64_restoring_divider_checker.
module int64_restoring_divider_test;

  localparam int W                = idiv_pkg::DATA_W;
  localparam logic FUNC_UNSIGNED  = 1'b0;
  localparam logic FUNC_SIGNED    = 1'b1;
  localparam int RANDOM_DIVISIONS = 1350;
  localparam int PHASES           = 6;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = W + 16;
  localparam logic [W-1:0] MIN_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = '1;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_valid    = 1'b0;
  logic         in_func     = FUNC_UNSIGNED;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor  = '0;
  logic         out_stall   = 1'b0;
  logic         in_stall;
  logic         out_valid;
  logic [W-1:0] out_quotient;
  logic [W-1:0] out_remainder;
  logic [1:0]   out_error;

  bit no_gaps;
  bit no_stalls;
  int mismatches;
  int outstanding;
  int checked;
  int issued;
  int zero_divisors;
  int overflows;
  int cycles;

  int64_restoring_divider dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_quotient (out_quotient),
    .out_remainder(out_remainder),
    .out_error    (out_error)
  );

  int64_restoring_divider_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_quotient (out_quotient),
    .out_remainder(out_remainder),
    .out_error    (out_error),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("int64_restoring_divider regression: fail");
    $finish;
  end

  // Hands one division to the block and returns at the edge that accepts it.
  task automatic issue_division(input logic f, input logic [W-1:0] a, input logic [W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_dividend <= a;
    in_divisor  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued++;
    if (b == '0) zero_divisors++;
    else if (f == FUNC_SIGNED && a == MIN_NEG && b == ALL_ONES) overflows++;
  endtask

  // The count from the checker is registered, so look only after a fresh edge.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Operands are drawn from classes that sit on the interesting boundaries.
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = MIN_NEG + W'($urandom_range(0, 3));
      1: v = ALL_ONES - W'($urandom_range(0, 7));
      2: v = W'($urandom_range(0, 15));
      3: v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W-1);
      4: v = {$urandom, $urandom} >> $urandom_range(1, W-1);
      5: v = ~({$urandom, $urandom} >> $urandom_range(1, W-1));
      6: v = MAX_POS - W'($urandom_range(0, 3));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  initial begin
    int           per_phase;
    logic         f;
    logic [W-1:0] a;
    logic [W-1:0] b;
    per_phase = RANDOM_DIVISIONS / PHASES;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Boundary operands in both modes, both error cases, large unsigned divisors.
    issue_division(FUNC_UNSIGNED, '0, 64'd1);
    issue_division(FUNC_UNSIGNED, ALL_ONES, 64'd1);
    issue_division(FUNC_UNSIGNED, ALL_ONES, ALL_ONES);
    issue_division(FUNC_UNSIGNED, ALL_ONES, MIN_NEG);
    issue_division(FUNC_UNSIGNED, ALL_ONES, MIN_NEG + 64'd1);
    issue_division(FUNC_UNSIGNED, MIN_NEG, MAX_POS);
    issue_division(FUNC_UNSIGNED, 64'd7, ALL_ONES);
    issue_division(FUNC_UNSIGNED, 64'd100, 64'd7);
    issue_division(FUNC_UNSIGNED, ALL_ONES, 64'd3);
    issue_division(FUNC_UNSIGNED, 64'd5, '0);
    issue_division(FUNC_UNSIGNED, '0, '0);
    issue_division(FUNC_UNSIGNED, MIN_NEG, ALL_ONES);
    issue_division(FUNC_SIGNED, MIN_NEG, ALL_ONES);
    issue_division(FUNC_SIGNED, MIN_NEG, 64'd1);
    issue_division(FUNC_SIGNED, MIN_NEG, MIN_NEG);
    issue_division(FUNC_SIGNED, MIN_NEG, 64'd2);
    issue_division(FUNC_SIGNED, -64'sd7, 64'd2);
    issue_division(FUNC_SIGNED, 64'd7, -64'sd2);
    issue_division(FUNC_SIGNED, -64'sd7, -64'sd2);
    issue_division(FUNC_SIGNED, MAX_POS, ALL_ONES);
    issue_division(FUNC_SIGNED, '0, ALL_ONES);
    issue_division(FUNC_SIGNED, ALL_ONES, MIN_NEG);
    issue_division(FUNC_SIGNED, 64'd1, ALL_ONES);
    issue_division(FUNC_SIGNED, ALL_ONES, '0);
    issue_division(FUNC_SIGNED, MAX_POS, MAX_POS);
    wait_for_results();

    // The first phases run back to back on one side or both, the rest idle at random.
    for (int phase = 0; phase < PHASES; phase++) begin
      no_gaps   = (phase == 0 || phase == 1);
      no_stalls = (phase == 0 || phase == 2);
      for (int n = 0; n < per_phase; n++) begin
        f = $urandom_range(0, 1) ? FUNC_SIGNED : FUNC_UNSIGNED;
        a = pick_operand();
        b = pick_operand();
        case ($urandom_range(0, 31))
          0: b = '0;
          1: begin
            f = FUNC_SIGNED;
            a = MIN_NEG;
            b = ALL_ONES;
          end
          default: ;
        endcase
        issue_division(f, a, b);
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
      wait_for_results();
    end

    no_gaps   = 1'b0;
    no_stalls = 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d divisions in unsigned and signed mode (%0d zero divisors, %0d overflows),",
             issued, zero_divisors, overflows);
    $display("with random input gaps and output stalls; %0d results checked.", checked);
    if (mismatches == 0) begin
      $display("int64_restoring_divider regression: pass");
    end else begin
      $display("int64_restoring_divider regression: fail");
    end
    $finish;
  end

  // The receiving side holds each result off for a random number of cycles.
  initial begin
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_stalls ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

endmodule
